### src/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types and constants of the streaming Simpson/trapezoid integrator:
// the operation record passed from the front end to the back end, the status
// codes and the radix-256 divide-by-three step.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int SAMPLE_W = 32;
  localparam int DX_W     = SAMPLE_W + 1;  // difference of two samples
  localparam int YSUM_W   = SAMPLE_W + 3;  // y0 + 4*y1 + y2
  localparam int MAG_S_W  = SAMPLE_W + 2;  // magnitude of any ysum
  localparam int PROD_W   = 2 * SAMPLE_W + 2;
  localparam int SUM_W    = 2 * SAMPLE_W;
  localparam int DIV_CHUNK  = 8;
  localparam int DIV_STAGES = 9;
  localparam int DIV_W      = DIV_CHUNK * DIV_STAGES;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FEW_POINTS = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  // One term d * s / k, k being 6 for a Simpson panel and 2 for a trapezoid.
  typedef struct packed {
    logic signed [DX_W-1:0]   dx;
    logic signed [YSUM_W-1:0] ysum;
    logic                     six;
  } term_t;

  // Work for the back end caused by one sample.
  typedef struct packed {
    term_t term_a;
    term_t term_b;
    logic  has_a;
    logic  has_b;
    logic  emit;
    logic  single;
  } op_t;

  // Long division by three of one 8-bit chunk, carrying the remainder.
  // Returns {quotient chunk, remainder}.
  function automatic logic [DIV_CHUNK+1:0] div3_chunk(input logic [1:0] rem_in,
                                                      input logic [DIV_CHUNK-1:0] chunk);
    logic [2:0]           cur;
    logic [1:0]           r;
    logic [DIV_CHUNK-1:0] q;
    r = rem_in;
    q = '0;
    for (int i = DIV_CHUNK - 1; i >= 0; i--) begin
      cur = {r, chunk[i]};
      if (cur >= 3'd3) begin
        q[i] = 1'b1;
        r    = 2'(cur - 3'd3);
      end else begin
        q[i] = 1'b0;
        r    = cur[1:0];
      end
    end
    return {q, r};
  endfunction

endpackage

### src/sti_front.sv
// ----------------------------------------------------------------------------
// sti_front
// Front end: holds the current triple, checks the spacing against the
// tolerance register and turns each sample into an operation for the back end.
// ----------------------------------------------------------------------------
module sti_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    sample_x,
  input  logic signed [31:0]    sample_y,
  input  logic                  last_sample,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           spacing_tolerance,
  output logic                  op_push,
  output sti_pkg::op_t          op_data,
  input  logic                  op_full
);
  import sti_pkg::*;

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_START,
    PH_MID
  } phase_t;

  phase_t                      phase;
  logic [SAMPLE_W-1:0]         tolerance;
  logic signed [SAMPLE_W-1:0]  start_x;
  logic signed [SAMPLE_W-1:0]  start_y;
  logic signed [SAMPLE_W-1:0]  mid_x;
  logic signed [SAMPLE_W-1:0]  mid_y;

  logic                        accept;
  logic                        need_push;
  logic signed [SAMPLE_W+1:0]  skew;
  logic [SAMPLE_W+1:0]         skew_mag;
  logic                        skewed;

  assign in_ready  = !op_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign op_push   = accept && need_push;

  // Difference of the two spacings of the triple being closed.
  assign skew     = 34'(sample_x) - 34'(mid_x) - 34'(mid_x) + 34'(start_x);
  assign skew_mag = skew[SAMPLE_W+1] ? 34'(34'sd0 - skew) : 34'(skew);
  assign skewed   = skew_mag > {2'b00, tolerance};

  always_comb begin
    op_data        = '0;
    op_data.emit   = last_sample;
    need_push      = last_sample;
    unique case (phase)
      PH_START: begin
        op_data.has_a       = 1'b1;
        op_data.term_a.dx   = 33'(sample_x) - 33'(start_x);
        op_data.term_a.ysum = 35'(start_y) + 35'(sample_y);
      end
      PH_MID: begin
        need_push     = 1'b1;
        op_data.has_a = 1'b1;
        if (skewed) begin
          op_data.has_b       = 1'b1;
          op_data.term_a.dx   = 33'(mid_x) - 33'(start_x);
          op_data.term_a.ysum = 35'(start_y) + 35'(mid_y);
          op_data.term_b.dx   = 33'(sample_x) - 33'(mid_x);
          op_data.term_b.ysum = 35'(mid_y) + 35'(sample_y);
        end else begin
          op_data.term_a.six  = 1'b1;
          op_data.term_a.dx   = 33'(sample_x) - 33'(start_x);
          op_data.term_a.ysum = 35'(start_y) + (35'(mid_y) <<< 2) + 35'(sample_y);
        end
      end
      default: begin
        op_data.single = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_EMPTY;
      tolerance <= '0;
    end else begin
      if (cfg_valid) begin
        tolerance <= spacing_tolerance;
      end
      if (accept) begin
        unique case (phase)
          PH_START: begin
            mid_x <= sample_x;
            mid_y <= sample_y;
          end
          default: begin
            start_x <= sample_x;
            start_y <= sample_y;
          end
        endcase
        // A last sample always leaves the triple empty for the next integral.
        if (last_sample) begin
          phase <= PH_EMPTY;
        end else if (phase == PH_START) begin
          phase <= PH_MID;
        end else begin
          phase <= PH_START;
        end
      end
    end
  end

endmodule

### src/sti_fifo.sv
// ----------------------------------------------------------------------------
// sti_fifo
// Short queue of operations between the front end and the back end.
// ----------------------------------------------------------------------------
module sti_fifo #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  sti_pkg::op_t push_data,
  output logic         full,
  input  logic         pop,
  output sti_pkg::op_t pop_data,
  output logic         empty
);
  import sti_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/sti_back.sv
// ----------------------------------------------------------------------------
// sti_back
// Back end: issues one term per cycle unless halted, forms the exact product,
// rounds and divides by two or six in a pipeline, adds it into the saturating
// accumulator. Emits the integral and status register when an integral ends.
// ----------------------------------------------------------------------------
module sti_back (
  input  logic               clk,
  input  logic               rst,
  input  sti_pkg::op_t       op_data,
  input  logic               op_empty,
  output logic               op_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] integral,
  output logic [1:0]         status
);
  import sti_pkg::*;

  typedef struct packed {
    logic has_term;
    logic neg;
    logic six;
    logic emit;
    logic single;
  } tok_t;

  logic                advance;
  logic                sub;
  logic                final_piece;
  term_t               pick;

  // Dispatch register.
  logic                s1_valid;
  tok_t                s1_tok;
  logic [SAMPLE_W-1:0] s1_mag_d;
  logic [MAG_S_W-1:0]  s1_mag_s;

  // Partial products.
  logic                s2_valid;
  tok_t                s2_tok;
  logic [SUM_W-1:0]    s2_pp_lo;
  logic [MAG_S_W-1:0]  s2_pp_hi;

  // Divider pipeline, entry 0 holds the rounded and halved product.
  logic                dv_valid [DIV_STAGES+1];
  tok_t                dv_tok   [DIV_STAGES+1];
  logic [DIV_W-1:0]    dv_word  [DIV_STAGES+1];
  logic [1:0]          dv_rem   [DIV_STAGES+1];

  // Signed term.
  logic                sg_valid;
  tok_t                sg_tok;
  logic signed [SUM_W+1:0] sg_term;

  logic signed [SUM_W-1:0] running_sum;
  logic                    overflow_seen;

  logic [PROD_W-1:0]       rounded;
  logic [SUM_W-1:0]        quotient;
  logic signed [SUM_W+1:0] addend;
  logic signed [SUM_W+1:0] wide_sum;
  logic                    fits;
  logic signed [SUM_W-1:0] sum_next;
  logic                    overflow_next;
  logic signed [DX_W-1:0]  mag_d_full;
  logic signed [YSUM_W-1:0] mag_s_full;

  // The whole back end moves together; it only halts when a finished
  // integral meets an output register that is still waiting to be taken.
  assign advance     = !(out_valid && !out_ready && sg_valid && sg_tok.emit);
  assign final_piece = !(op_data.has_b && !sub);
  assign op_pop      = advance && !op_empty && final_piece;
  assign pick        = sub ? op_data.term_b : op_data.term_a;
  assign mag_d_full  = pick.dx[DX_W-1] ? DX_W'(-pick.dx) : pick.dx;
  assign mag_s_full  = pick.ysum[YSUM_W-1] ? YSUM_W'(-pick.ysum) : pick.ysum;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub      <= 1'b0;
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= !op_empty;
      if (!op_empty) begin
        sub <= !final_piece;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tok.has_term <= op_data.has_a;
      s1_tok.neg      <= pick.dx[DX_W-1] ^ pick.ysum[YSUM_W-1];
      s1_tok.six      <= pick.six;
      s1_tok.emit     <= op_data.emit && final_piece;
      s1_tok.single   <= op_data.single;
      s1_mag_d        <= mag_d_full[SAMPLE_W-1:0];
      s1_mag_s        <= mag_s_full[MAG_S_W-1:0];
    end
  end

  // Magnitude of d fits 32 bits; the magnitude of s carries two more bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_tok   <= s1_tok;
      s2_pp_lo <= SUM_W'(s1_mag_d) * SUM_W'(s1_mag_s[SAMPLE_W-1:0]);
      s2_pp_hi <= MAG_S_W'(s1_mag_d) * MAG_S_W'(s1_mag_s[MAG_S_W-1:SAMPLE_W]);
    end
  end

  // Add half the divisor, then take out the factor two by a shift.
  assign rounded = PROD_W'(s2_pp_lo) + {s2_pp_hi, {SAMPLE_W{1'b0}}}
                 + (s2_tok.six ? PROD_W'(3) : PROD_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (advance) begin
      dv_valid[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dv_tok[0]  <= s2_tok;
      dv_word[0] <= DIV_W'(rounded[PROD_W-1:1]);
      dv_rem[0]  <= 2'd0;
    end
  end

  // Division by three, one byte per stage from the top down.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int LSB = DIV_W - DIV_CHUNK * (k + 1);
    logic [DIV_CHUNK+1:0] step;
    logic [DIV_W-1:0]     word_next;

    assign step = div3_chunk(dv_rem[k], dv_word[k][LSB +: DIV_CHUNK]);

    always_comb begin
      word_next = dv_word[k];
      word_next[LSB +: DIV_CHUNK] = step[DIV_CHUNK+1:2];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (advance) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dv_tok[k+1] <= dv_tok[k];
        if (dv_tok[k].six) begin
          dv_word[k+1] <= word_next;
          dv_rem[k+1]  <= step[1:0];
        end else begin
          dv_word[k+1] <= dv_word[k];
          dv_rem[k+1]  <= dv_rem[k];
        end
      end
    end
  end

  assign quotient = dv_word[DIV_STAGES][SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sg_valid <= 1'b0;
    end else if (advance) begin
      sg_valid <= dv_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sg_tok  <= dv_tok[DIV_STAGES];
      sg_term <= dv_tok[DIV_STAGES].neg ? (SUM_W+2)'(-{2'b00, quotient})
                                        : signed'({2'b00, quotient});
    end
  end

  // Saturating accumulate.
  assign addend   = sg_tok.has_term ? sg_term : '0;
  assign wide_sum = {{2{running_sum[SUM_W-1]}}, running_sum} + addend;
  assign fits     = (wide_sum[SUM_W+1:SUM_W-1] == 3'b000)
                 || (wide_sum[SUM_W+1:SUM_W-1] == 3'b111);

  always_comb begin
    overflow_next = overflow_seen;
    if (fits) begin
      sum_next = wide_sum[SUM_W-1:0];
    end else begin
      overflow_next = 1'b1;
      sum_next      = wide_sum[SUM_W+1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (advance && sg_valid) begin
        if (sg_tok.emit) begin
          running_sum   <= '0;
          overflow_seen <= 1'b0;
        end else begin
          running_sum   <= sum_next;
          overflow_seen <= overflow_next;
        end
      end
      if (advance && sg_valid && sg_tok.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && sg_valid && sg_tok.emit) begin
      if (sg_tok.single) begin
        integral <= '0;
        status   <= STATUS_FEW_POINTS;
      end else begin
        integral <= sum_next;
        status   <= overflow_next ? STATUS_SATURATED : STATUS_OK;
      end
    end
  end

endmodule

### src/simpson_trapezoid_integrator.sv
// ----------------------------------------------------------------------------
// simpson_trapezoid_integrator
// Streaming composite Simpson integrator over signed Q16.16 (x, y) samples
// with a trapezoid fallback for uneven spacing; Q32.32 saturated result.
// ----------------------------------------------------------------------------
// The block takes one sample per cycle unless stalled; samples form overlapping
// triples starting at even positions; each triple adds h/6*(y0+4*y1+y2) or,
// when its two spacings differ by more than spacing_tolerance x LSBs, the two
// trapezoids of the triple. An even sample count closes with one trapezoid.
// The sample marked last_sample yields one item on the output channel: the
// integral in signed Q32.32 (saturated) and a status of 0 for ok, 1 for fewer
// than two points, or 2 when the accumulator saturated. Every term is formed
// exactly and rounded to nearest, ties away from zero, before accumulation.
// Rate: one sample item per cycle sustained while the queue has room. The
// back end runs one term per cycle, unless halted, through a single
// multiply/divide datapath, so a triple that falls back to two trapezoids
// occupies it once per term; the queue between the front and back ends
// absorbs such bursts. The back end only stalls when a finished integral
// finds the previous result still waiting on the output. spacing_tolerance
// is written through the cfg channel, which is always ready, and should
// only be changed while no integral is in progress.
// ----------------------------------------------------------------------------
module simpson_trapezoid_integrator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] sample_x,
  input  logic signed [31:0] sample_y,
  input  logic               last_sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        spacing_tolerance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] integral,
  output logic [1:0]         status
);
  import sti_pkg::*;

  // Operations flow from the classifying front end through the queue.
  op_t  push_op;
  op_t  head_op;
  logic push;
  logic pop;
  logic full;
  logic empty;

  // The front end holds the triple and the tolerance register.
  sti_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .sample_x          (sample_x),
    .sample_y          (sample_y),
    .last_sample       (last_sample),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .spacing_tolerance (spacing_tolerance),
    .op_push           (push),
    .op_data           (push_op),
    .op_full           (full)
  );

  sti_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_op),
    .full      (full),
    .pop       (pop),
    .pop_data  (head_op),
    .empty     (empty)
  );

  // The back end does the arithmetic and owns the output register.
  sti_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_data   (head_op),
    .op_empty  (empty),
    .op_pop    (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .integral  (integral),
    .status    (status)
  );

endmodule
